// ----- design/trapezoid_signed_distance_assert.svh -----
// Assertion macros for the trapezoid_signed_distance RTL.
`ifndef TRAPEZOID_SIGNED_DISTANCE_ASSERT_SVH
`define TRAPEZOID_SIGNED_DISTANCE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trapezoid_signed_distance check failed");

// Check cons in the cycle after ante.
`define TSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trapezoid_signed_distance check failed");

`endif

// ----- design/tsd_pkg.sv -----
`default_nettype none
package tsd_pkg;

  typedef struct packed {
    logic ok;
    logic zero;
  } lane_flags_t;

  typedef enum logic [1:0] {
    EDGE_LEFT,
    EDGE_TOP,
    EDGE_RIGHT,
    EDGE_BOTTOM
  } edge_sel_t;

  typedef enum logic [2:0] {
    REG_BL_X,
    REG_BL_Y,
    REG_BR_X,
    REG_BR_Y,
    REG_TL_X,
    REG_TL_Y,
    REG_TR_X,
    REG_TR_Y
  } reg_index_t;

  // lane stages: three front stages, (cw+2) root stages, (2cw+2) quotient stages, one round
  function automatic int lane_lat(input int cw);
    return 3 * cw + 8;
  endfunction

endpackage
`default_nettype wire

// ----- design/trapezoid_signed_distance.sv -----
// An accepted point passes the input register, the edge lanes and the output register to its result.
// Throughput: one point per clock; a stalled result freezes the whole pipeline.
// Latency is set by the edge lanes: one root bit and one quotient bit per stage.
// Reset: rst clears the corner registers to zero and empties the pipeline.
`default_nettype none
`include "trapezoid_signed_distance_assert.svh"
module trapezoid_signed_distance import tsd_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         point_valid,
  output logic                              point_stall,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic signed [COORD_BITS-1:0]      shape_distance,
  output logic                              is_inside,
  output logic                              degenerate,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [COORD_BITS-1:0]        cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int LL = lane_lat(CW);

  logic signed [CW-1:0] bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y;
  logic signed [CW-1:0] ip_x, ip_y;
  logic                 en;

  logic signed [CW-1:0] x_lower, y_lower, y_upper;
  edge_sel_t            sel0;

  logic                 dl_valid [0:LL];
  edge_sel_t            dl_sel   [1:LL];

  logic        [CW-1:0] ln_dist  [0:3];
  lane_flags_t          ln_f     [0:3];

  logic                 in_shape, any, degen;
  logic        [CW-1:0] dmin, dout;
  edge_sel_t            sel_last;

  assign en          = !(result_valid && result_stall);
  assign point_stall = !en;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bl_x <= '0; bl_y <= '0; br_x <= '0; br_y <= '0;
      tl_x <= '0; tl_y <= '0; tr_x <= '0; tr_y <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_BL_X: bl_x <= cfg_data;
        REG_BL_Y: bl_y <= cfg_data;
        REG_BR_X: br_x <= cfg_data;
        REG_BR_Y: br_y <= cfg_data;
        REG_TL_X: tl_x <= cfg_data;
        REG_TL_Y: tl_y <= cfg_data;
        REG_TR_X: tr_x <= cfg_data;
        REG_TR_Y: tr_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    x_lower = (bl_x > tl_x) ? bl_x : tl_x;
    y_lower = (bl_y > br_y) ? bl_y : br_y;
    y_upper = (tl_y < tr_y) ? tl_y : tr_y;
    if (ip_y >= y_upper && tl_x <= ip_x && ip_x <= tr_x) begin
      sel0 = EDGE_TOP;
    end else if (ip_y <= y_lower && bl_x <= ip_x && ip_x <= br_x) begin
      sel0 = EDGE_BOTTOM;
    end else if (ip_x <= x_lower) begin
      sel0 = EDGE_LEFT;
    end else begin
      sel0 = EDGE_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip_x <= point_x;
      ip_y <= point_y;
      dl_sel[1] <= sel0;
      for (int k = 1; k < LL; k++) begin
        dl_sel[k+1] <= dl_sel[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LL; k++) begin
        dl_valid[k] <= 1'b0;
      end
    end else if (en) begin
      dl_valid[0] <= point_valid;
      for (int k = 0; k < LL; k++) begin
        dl_valid[k+1] <= dl_valid[k];
      end
    end
  end

  tsd_lane #(.CW(CW)) u_left (
    .clk(clk), .en(en), .above(1'b0), .px(ip_x), .py(ip_y),
    .x1(bl_x), .y1(bl_y), .x2(tl_x), .y2(tl_y),
    .lane_dist(ln_dist[EDGE_LEFT]), .flags(ln_f[EDGE_LEFT])
  );

  tsd_lane #(.CW(CW)) u_top (
    .clk(clk), .en(en), .above(1'b0), .px(ip_x), .py(ip_y),
    .x1(tl_x), .y1(tl_y), .x2(tr_x), .y2(tr_y),
    .lane_dist(ln_dist[EDGE_TOP]), .flags(ln_f[EDGE_TOP])
  );

  tsd_lane #(.CW(CW)) u_right (
    .clk(clk), .en(en), .above(1'b0), .px(ip_x), .py(ip_y),
    .x1(tr_x), .y1(tr_y), .x2(br_x), .y2(br_y),
    .lane_dist(ln_dist[EDGE_RIGHT]), .flags(ln_f[EDGE_RIGHT])
  );

  tsd_lane #(.CW(CW)) u_bottom (
    .clk(clk), .en(en), .above(1'b1), .px(ip_x), .py(ip_y),
    .x1(br_x), .y1(br_y), .x2(bl_x), .y2(bl_y),
    .lane_dist(ln_dist[EDGE_BOTTOM]), .flags(ln_f[EDGE_BOTTOM])
  );

  always_comb begin
    in_shape = ln_f[0].ok && ln_f[1].ok && ln_f[2].ok && ln_f[3].ok;
    sel_last = dl_sel[LL];
    any      = 1'b0;
    degen    = 1'b0;
    dmin     = '0;
    for (int k = 0; k < 4; k++) begin
      if (ln_f[k].zero) begin
        degen = 1'b1;
      end else if (!any || ln_dist[k] < dmin) begin
        dmin = ln_dist[k];
        any  = 1'b1;
      end
    end
    if (in_shape) begin
      dout = CW'(0) - dmin;
    end else begin
      degen = ln_f[sel_last].zero;
      dout  = degen ? '0 : ln_dist[sel_last];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dl_valid[LL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shape_distance <= dout;
      is_inside      <= in_shape;
      degenerate     <= degen;
    end
  end

  `TSD_ASSERT_SAME(a_inside_nonpos, result_valid && is_inside,
                   shape_distance[CW-1] || shape_distance == '0)
  `TSD_ASSERT_SAME(a_outside_nonneg, result_valid && !is_inside, !shape_distance[CW-1])
  `TSD_ASSERT_SAME(a_outside_degen_zero, result_valid && !is_inside && degenerate,
                   shape_distance == '0)
  `TSD_ASSERT_NEXT(a_stall_freeze, result_valid && result_stall,
                   result_valid && $stable(dl_valid[LL]))

endmodule
`default_nettype wire

// ----- design/tsd_lane.sv -----
`default_nettype none
module tsd_lane import tsd_pkg::*; #(
  parameter int CW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic                 above,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  input  wire logic signed [CW-1:0] x1,
  input  wire logic signed [CW-1:0] y1,
  input  wire logic signed [CW-1:0] x2,
  input  wire logic signed [CW-1:0] y2,
  output logic             [CW-1:0] lane_dist,
  output lane_flags_t               flags
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int CXW = PW + 1;
  localparam int NW  = PW;
  localparam int SW  = CW + 2;
  localparam int LW  = 2 * SW;
  localparam int RW  = SW + 3;

  logic signed [DW-1:0] dx, dy, ex, ey;
  logic signed [PW-1:0] p1, p2, sq1, sq2;
  logic                 dxneg, dxzero, zero2;

  logic        [LW-1:0] sq_n    [0:SW];
  logic        [RW-1:0] sq_rem  [0:SW];
  logic        [SW-1:0] sq_root [0:SW];
  logic        [NW-1:0] sq_c    [0:SW];
  lane_flags_t          sq_f    [0:SW];

  logic        [NW-1:0] dv_n    [1:NW];
  logic        [SW-1:0] dv_rem  [1:NW];
  logic        [NW-1:0] dv_q    [1:NW];
  logic        [SW-1:0] dv_d    [1:NW];
  lane_flags_t          dv_f    [1:NW];

  logic signed [CXW-1:0] c;
  logic        [CXW-1:0] cmag_w;
  logic                  cneg, czero, sneg, prodneg;
  logic        [PW-1:0]  l2;

  logic        [LW-1:0] sqn_next    [0:SW-1];
  logic        [RW-1:0] sqrem_next  [0:SW-1];
  logic        [SW-1:0] sqroot_next [0:SW-1];
  logic        [RW-1:0] sq_sh       [0:SW-1];
  logic        [RW-1:0] sq_tr       [0:SW-1];

  logic        [NW-1:0] dvi_n   [0:NW-1];
  logic        [SW-1:0] dvi_rem [0:NW-1];
  logic        [NW-1:0] dvi_q   [0:NW-1];
  logic        [SW-1:0] dvi_d   [0:NW-1];
  lane_flags_t          dvi_f   [0:NW-1];
  logic        [SW:0]   dv_sh   [0:NW-1];
  logic        [NW-1:0] dvn_next   [0:NW-1];
  logic        [SW-1:0] dvrem_next [0:NW-1];
  logic        [NW-1:0] dvq_next   [0:NW-1];

  logic        [SW:0]   twice;
  logic        [NW:0]   qr;
  logic                 sat;

  always_comb begin
    c       = {p1[PW-1], p1} - {p2[PW-1], p2};
    cneg    = c[CXW-1];
    czero   = (c == '0);
    cmag_w  = cneg ? (CXW'(0) - c) : c;
    l2      = sq1 + sq2;
    sneg    = dxneg || (dxzero && above);
    prodneg = sneg ^ cneg;
  end

  always_comb begin
    for (int k = 0; k < SW; k++) begin
      sq_sh[k] = {sq_rem[k][RW-3:0], sq_n[k][LW-1:LW-2]};
      sq_tr[k] = {1'b0, sq_root[k], 2'b01};
      if (sq_sh[k] >= sq_tr[k]) begin
        sqrem_next[k]  = sq_sh[k] - sq_tr[k];
        sqroot_next[k] = {sq_root[k][SW-2:0], 1'b1};
      end else begin
        sqrem_next[k]  = sq_sh[k];
        sqroot_next[k] = {sq_root[k][SW-2:0], 1'b0};
      end
      sqn_next[k] = {sq_n[k][LW-3:0], 2'b00};
    end
  end

  always_comb begin
    dvi_n[0]   = sq_c[SW];
    dvi_rem[0] = '0;
    dvi_q[0]   = '0;
    dvi_d[0]   = sq_root[SW];
    dvi_f[0]   = sq_f[SW];
    for (int k = 1; k < NW; k++) begin
      dvi_n[k]   = dv_n[k];
      dvi_rem[k] = dv_rem[k];
      dvi_q[k]   = dv_q[k];
      dvi_d[k]   = dv_d[k];
      dvi_f[k]   = dv_f[k];
    end
    for (int k = 0; k < NW; k++) begin
      dv_sh[k] = {dvi_rem[k], dvi_n[k][NW-1]};
      if (dv_sh[k] >= {1'b0, dvi_d[k]}) begin
        dvrem_next[k] = SW'(dv_sh[k] - {1'b0, dvi_d[k]});
        dvq_next[k]   = {dvi_q[k][NW-2:0], 1'b1};
      end else begin
        dvrem_next[k] = dv_sh[k][SW-1:0];
        dvq_next[k]   = {dvi_q[k][NW-2:0], 1'b0};
      end
      dvn_next[k] = {dvi_n[k][NW-2:0], 1'b0};
    end
  end

  always_comb begin
    twice = {dv_rem[NW], 1'b0};
    qr    = {1'b0, dv_q[NW]} + ((twice >= {1'b0, dv_d[NW]}) ? (NW+1)'(1) : (NW+1)'(0));
    sat   = |qr[NW:CW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {x2[CW-1], x2} - {x1[CW-1], x1};
      dy <= {y2[CW-1], y2} - {y1[CW-1], y1};
      ex <= {px[CW-1], px} - {x1[CW-1], x1};
      ey <= {py[CW-1], py} - {y1[CW-1], y1};

      p1     <= dx * ey;
      p2     <= dy * ex;
      sq1    <= dx * dx;
      sq2    <= dy * dy;
      dxneg  <= dx[DW-1];
      dxzero <= (dx == '0);
      zero2  <= (dx == '0) && (dy == '0);

      sq_n[0]      <= {{(LW-PW){1'b0}}, l2};
      sq_rem[0]    <= '0;
      sq_root[0]   <= '0;
      sq_c[0]      <= cmag_w[NW-1:0];
      sq_f[0].ok   <= czero || (above ? !prodneg : prodneg);
      sq_f[0].zero <= zero2;
      for (int k = 0; k < SW; k++) begin
        sq_n[k+1]    <= sqn_next[k];
        sq_rem[k+1]  <= sqrem_next[k];
        sq_root[k+1] <= sqroot_next[k];
        sq_c[k+1]    <= sq_c[k];
        sq_f[k+1]    <= sq_f[k];
      end

      for (int k = 0; k < NW; k++) begin
        dv_n[k+1]   <= dvn_next[k];
        dv_rem[k+1] <= dvrem_next[k];
        dv_q[k+1]   <= dvq_next[k];
        dv_d[k+1]   <= dvi_d[k];
        dv_f[k+1]   <= dvi_f[k];
      end

      lane_dist <= sat ? {1'b0, {(CW-1){1'b1}}} : qr[CW-1:0];
      flags     <= dv_f[NW];
    end
  end

endmodule
`default_nettype wire

// ----- verif/tsd_checker.sv -----
`timescale 1ns / 100ps
module tsd_checker import tsd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               point_valid,
  input  wire logic               point_stall,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic               result_valid,
  input  wire logic               result_stall,
  input  wire logic signed [31:0] shape_distance,
  input  wire logic               is_inside,
  input  wire logic               degenerate,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic signed [31:0] dval;
    logic               in_shape;
    logic               degen;
  } distance_word_t;

  localparam logic [127:0] DIST_MAX = 128'h7fff_ffff;

  logic signed [31:0] corner [8];
  distance_word_t     expected_q [$];

  function automatic void edge_lane(
    input  logic signed [63:0] px, py, x1, y1, x2, y2,
    input  bit                 above,
    output bit                 ok,
    output logic [31:0]        dval,
    output bit                 zero
  );
    logic signed [127:0] wdx, wdy, wpx, wpy, cprod;
    logic [127:0] mc, len2, quo, rem;
    logic [63:0] root, trial;
    int s, cs;
    wdx = x2 - x1;
    wdy = y2 - y1;
    wpx = px - x1;
    wpy = py - y1;
    cprod = wdx * wpy - wdy * wpx;
    cs = cprod < 0 ? -1 : (cprod != 0 ? 1 : 0);
    s = wdx > 0 ? 1 : (wdx < 0 ? -1 : (above ? -1 : 1));
    ok = above ? (s * cs >= 0) : (s * cs <= 0);
    zero = (wdx == 0) && (wdy == 0);
    dval = '0;
    if (!zero) begin
      mc = cprod < 0 ? -cprod : cprod;
      len2 = wdx * wdx + wdy * wdy;
      root = '0;
      for (int b = 51; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if ({64'd0, trial} * {64'd0, trial} <= len2) root = trial;
      end
      quo = mc / {64'd0, root};
      rem = mc % {64'd0, root};
      if (2 * rem >= {64'd0, root}) quo = quo + 1;
      dval = quo > DIST_MAX ? DIST_MAX[31:0] : quo[31:0];
    end
  endfunction

  function automatic distance_word_t predict_distance(input logic signed [31:0] x, y);
    logic signed [63:0] px, py, blx, bly, brx, bry, tlx, tly, trx, try_y;
    logic signed [63:0] x_lower, y_lower, y_upper;
    bit ok [4];
    bit zero [4];
    logic [31:0] d [4];
    logic [31:0] best;
    bit any;
    edge_sel_t sel;
    distance_word_t w;
    px = x; py = y;
    blx = corner[REG_BL_X]; bly = corner[REG_BL_Y];
    brx = corner[REG_BR_X]; bry = corner[REG_BR_Y];
    tlx = corner[REG_TL_X]; tly = corner[REG_TL_Y];
    trx = corner[REG_TR_X]; try_y = corner[REG_TR_Y];
    edge_lane(px, py, blx, bly, tlx, tly, 0, ok[EDGE_LEFT], d[EDGE_LEFT], zero[EDGE_LEFT]);
    edge_lane(px, py, tlx, tly, trx, try_y, 0, ok[EDGE_TOP], d[EDGE_TOP], zero[EDGE_TOP]);
    edge_lane(px, py, trx, try_y, brx, bry, 0, ok[EDGE_RIGHT], d[EDGE_RIGHT],
              zero[EDGE_RIGHT]);
    edge_lane(px, py, brx, bry, blx, bly, 1, ok[EDGE_BOTTOM], d[EDGE_BOTTOM],
              zero[EDGE_BOTTOM]);
    w.in_shape = ok[0] && ok[1] && ok[2] && ok[3];
    w.degen = 0;
    if (w.in_shape) begin
      any = 0;
      best = '0;
      for (int k = 0; k < 4; k++) begin
        if (zero[k]) begin
          w.degen = 1;
        end else if (!any || d[k] < best) begin
          best = d[k];
          any = 1;
        end
      end
      w.dval = -$signed(best);
    end else begin
      x_lower = blx > tlx ? blx : tlx;
      y_lower = bly > bry ? bly : bry;
      y_upper = tly < try_y ? tly : try_y;
      if (py >= y_upper && tlx <= px && px <= trx) sel = EDGE_TOP;
      else if (py <= y_lower && blx <= px && px <= brx) sel = EDGE_BOTTOM;
      else if (px <= x_lower) sel = EDGE_LEFT;
      else sel = EDGE_RIGHT;
      w.dval = d[sel];
      w.degen = zero[sel];
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_val);
    $display("%0t: %s got %h expected %h", $realtime, what, got, exp_val);
    errors++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    distance_word_t e;
    if (rst) begin
      for (int i = 0; i < 8; i++) corner[i] <= '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) corner[cfg_index] <= cfg_data;
      if (point_valid && !point_stall)
        expected_q.push_back(predict_distance(point_x, point_y));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", shape_distance, '0);
        end else begin
          e = expected_q.pop_front();
          if (shape_distance !== e.dval)
            report_mismatch("shape_distance", shape_distance, e.dval);
          if (is_inside !== e.in_shape) report_mismatch("is_inside", is_inside, e.in_shape);
          if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
        end
      end
    end
  end

endmodule

// ----- verif/tb_trapezoid_signed_distance.sv -----
`timescale 1ns / 100ps
module tb_trapezoid_signed_distance import tsd_pkg::*;;

  localparam int DRAIN_CYCLES = 3 * 32 + 30;

  logic               clk;
  logic               rst;
  logic               point_valid;
  logic               point_stall;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               result_valid;
  logic               result_stall;
  logic signed [31:0] shape_distance;
  logic               is_inside;
  logic               degenerate;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 errors;
  int                 pending;
  int                 idle_pct;
  int                 stall_pct;

  logic signed [31:0] shape [8];

  trapezoid_signed_distance u_top (
    .clk, .rst, .point_valid, .point_stall, .point_x, .point_y,
    .result_valid, .result_stall, .shape_distance, .is_inside, .degenerate,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tsd_checker u_checker (
    .clk, .rst, .point_valid, .point_stall, .point_x, .point_y,
    .result_valid, .result_stall, .shape_distance, .is_inside, .degenerate,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("trapezoid_signed_distance: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    result_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  task automatic send_point(input logic signed [31:0] x, y);
    while ($urandom_range(99) < idle_pct) begin
      point_valid <= 0;
      @(posedge clk);
    end
    point_x <= x;
    point_y <= y;
    point_valid <= 1;
    @(posedge clk);
    while (point_stall) @(posedge clk);
  endtask

  task automatic drain_results;
    point_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_shape;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= reg_index_t'(i);
      cfg_data <= shape[i];
      cfg_valid <= 1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic signed [31:0] blx, bly, brx, bry, tlx, tly, trx, tryv);
    shape[REG_BL_X] = blx; shape[REG_BL_Y] = bly;
    shape[REG_BR_X] = brx; shape[REG_BR_Y] = bry;
    shape[REG_TL_X] = tlx; shape[REG_TL_Y] = tly;
    shape[REG_TR_X] = trx; shape[REG_TR_Y] = tryv;
    write_shape();
  endtask

  function automatic logic signed [31:0] near_coord(input logic signed [31:0] a, b);
    longint lo, hi, span;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    span = hi - lo + 64'd131072;
    lo = lo - span / 4;
    return 32'(lo + longint'($urandom_range(0, 32'(span + span / 2 > 64'hffff_fffe ?
                                                    64'hffff_fffe : span + span / 2))));
  endfunction

  task automatic random_burst(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20)
        send_point($urandom, $urandom);
      else
        send_point(near_coord(shape[REG_BL_X] < shape[REG_TL_X] ? shape[REG_BL_X] :
                              shape[REG_TL_X],
                              shape[REG_BR_X] > shape[REG_TR_X] ? shape[REG_BR_X] :
                              shape[REG_TR_X]),
                   near_coord(shape[REG_BL_Y] < shape[REG_BR_Y] ? shape[REG_BL_Y] :
                              shape[REG_BR_Y],
                              shape[REG_TL_Y] > shape[REG_TR_Y] ? shape[REG_TL_Y] :
                              shape[REG_TR_Y]));
    end
  endtask

  task automatic mixed_phases;
    idle_pct = 0;  stall_pct = 0;  random_burst(60);
    idle_pct = 82; stall_pct = 0;  random_burst(60);
    idle_pct = 0;  stall_pct = 82; random_burst(60);
    idle_pct = 28; stall_pct = 28; random_burst(60);
  endtask

  task automatic random_shape(input int reach);
    logic signed [31:0] r [8];
    for (int i = 0; i < 8; i++) r[i] = $signed($urandom_range(0, 2 * reach)) - reach;
    set_shape(r[0] - reach, r[1] - reach, r[2] + reach, r[3] - reach,
              r[4] - reach, r[5] + reach, r[6] + reach, r[7] + reach);
  endtask

  initial begin
    rst = 1;
    point_valid = 0;
    point_x = '0;
    point_y = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 8; i++) shape[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // all corners at the origin: every edge has zero length
    send_point(0, 0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    send_point(32'sh0001_0000, -32'sh0001_0000);
    drain_results();

    set_shape(-32'sh0004_0000, -32'sh0002_0000, 32'sh0004_0000, -32'sh0002_0000,
              -32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000);
    send_point(0, 0);
    send_point(0, 32'sh0001_8000);
    send_point(0, 32'sh0005_0000);
    send_point(0, -32'sh0005_0000);
    send_point(-32'sh0006_0000, 0);
    send_point(32'sh0006_0000, 0);
    send_point(-32'sh0004_0000, -32'sh0002_0000);
    send_point(32'sh0002_0000, 32'sh0002_0000);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7fff_ffff);
    drain_results();
    mixed_phases();
    drain_results();

    // vertical sides
    set_shape(-32'sh0003_0000, 0, 32'sh0003_0000, 0,
              -32'sh0003_0000, 32'sh0004_0000, 32'sh0003_0000, 32'sh0004_0000);
    send_point(-32'sh0003_0000, 32'sh0002_0000);
    send_point(-32'sh0005_0000, 32'sh0002_0000);
    send_point(32'sh0005_0000, 32'sh0002_0000);
    mixed_phases();
    drain_results();

    // extreme corners: distances saturate
    set_shape(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(0, 0);
    send_point(32'sh8000_0000, 0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    mixed_phases();
    drain_results();

    // collapsed top edge: triangle
    set_shape(-32'sh0004_0000, 0, 32'sh0004_0000, 0, 0, 32'sh0003_0000, 0, 32'sh0003_0000);
    send_point(0, 32'sh0001_0000);
    send_point(0, 32'sh0006_0000);
    mixed_phases();
    drain_results();

    random_shape(32'sh0010_0000);
    mixed_phases();
    drain_results();

    random_shape(32'sh0200_0000);
    idle_pct = 0; stall_pct = 0;
    random_burst(40);
    drain_results();
    random_burst(40);
    mixed_phases();
    drain_results();

    idle_pct = 0; stall_pct = 0;
    drain_results();
    if (errors == 0) begin
      $display("trapezoid_signed_distance: match");
    end else begin
      $display("trapezoid_signed_distance: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tsd_pkg.sv
design/tsd_lane.sv
design/trapezoid_signed_distance.sv
verif/tsd_checker.sv
verif/tb_trapezoid_signed_distance.sv
